// ----- design/lhpc_pkg.sv -----
// Package: shared constants and types of the pixel classifier.
package lhpc_pkg;

    localparam int CLASSES_DEF     = 8;
    localparam int BANDS_DEF       = 4;
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int SAMPLE_FIELDS   = 4;
    localparam int WEIGHT_BITS     = 16;
    localparam int BIAS_BITS       = 32;
    localparam int COLOR_BITS      = 24;
    localparam int WORD_BITS       = 32;

    typedef enum logic [1:0] {
        MODE_WEIGHT   = 2'd0,
        MODE_BIAS     = 2'd1,
        MODE_COLOR    = 2'd2,
        MODE_CLASSIFY = 2'd3
    } mode_t;

    localparam logic [0:0] CFG_CLASS_COUNT = 1'b0;
    localparam logic [0:0] CFG_ENABLE      = 1'b1;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_DISABLED = 1'b1;

endpackage

// ----- design/lhpc_if.sv -----
// Interfaces: pixel/loader input, result output and configuration write channels.
interface lhpc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [2:0]  class_slot;
    logic [1:0]  band_slot;
    logic signed [31:0] table_word;
    logic [11:0] band_sample_0;
    logic [11:0] band_sample_1;
    logic [11:0] band_sample_2;
    logic [11:0] band_sample_3;
    modport source (output valid, mode, class_slot, band_slot, table_word,
                    band_sample_0, band_sample_1, band_sample_2, band_sample_3,
                    input ready);
    modport sink   (input valid, mode, class_slot, band_slot, table_word,
                    band_sample_0, band_sample_1, band_sample_2, band_sample_3,
                    output ready);
endinterface

interface lhpc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] chosen_class;
    logic [7:0] color_red;
    logic [7:0] color_green;
    logic [7:0] color_blue;
    logic       fallback_used;
    logic       status;
    modport source (output valid, chosen_class, color_red, color_green, color_blue,
                    fallback_used, status, input ready);
    modport sink   (input valid, chosen_class, color_red, color_green, color_blue,
                    fallback_used, status, output ready);
endinterface

interface lhpc_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/lhpc_lane.sv -----
// One class lane: holds the class weights and bias, registers the dot product.
module lhpc_lane #(
    parameter int BANDS       = lhpc_pkg::BANDS_DEF,
    parameter int SAMPLE_BITS = lhpc_pkg::SAMPLE_BITS_DEF,
    parameter int SCORE_BITS  = 34
) (
    input  logic                                        clk,
    input  logic                                        wr_weight,
    input  logic                                        wr_bias,
    input  logic [(BANDS > 1 ? $clog2(BANDS) : 1)-1:0]  wr_band,
    input  logic [lhpc_pkg::WORD_BITS-1:0]              wr_word,
    input  logic                                        calc,
    input  logic [BANDS*SAMPLE_BITS-1:0]                samples,
    output logic signed [SCORE_BITS-1:0]                score,
    output logic                                        above
);
    import lhpc_pkg::*;

    localparam int PROD_BITS = SAMPLE_BITS + WEIGHT_BITS + 1;
    localparam int CMP_BITS  = SCORE_BITS > BIAS_BITS ? SCORE_BITS : BIAS_BITS;

    logic signed [WEIGHT_BITS-1:0] weight_reg [BANDS];
    logic signed [BIAS_BITS-1:0]   bias_reg;
    logic signed [PROD_BITS-1:0]   prod_reg [BANDS];
    logic                          stage_reg;
    logic signed [SCORE_BITS-1:0]  sum;

    // Load table words for this class.
    always_ff @(posedge clk)
    begin
        for (int b = 0; b < BANDS; b++)
        begin
            if (wr_weight && wr_band == b[$bits(wr_band)-1:0])
                weight_reg[b] <= wr_word[WEIGHT_BITS-1:0];
        end
        if (wr_bias)
            bias_reg <= wr_word;
    end

    // Stage one: per-band products.
    always_ff @(posedge clk)
    begin
        stage_reg <= calc;
        for (int b = 0; b < BANDS; b++)
            prod_reg[b] <= $signed({1'b0, samples[b*SAMPLE_BITS +: SAMPLE_BITS]})
                           * weight_reg[b];
    end

    // Sum products.
    always_comb
    begin
        sum = '0;
        for (int b = 0; b < BANDS; b++)
            sum = sum + SCORE_BITS'(prod_reg[b]);
    end

    // Stage two: score and threshold flag, compared at the wider of both widths.
    always_ff @(posedge clk)
    begin
        if (stage_reg)
        begin
            score <= sum;
            above <= CMP_BITS'(sum) > CMP_BITS'(bias_reg);
        end
    end

endmodule

// ----- design/lhpc_merge.sv -----
// Merge stage: picks the winning class from the scores and flags of the lanes in use.
module lhpc_merge #(
    parameter int CLASSES    = lhpc_pkg::CLASSES_DEF,
    parameter int SCORE_BITS = 34
) (
    input  logic                          clk,
    input  logic [CLASSES*SCORE_BITS-1:0] scores,
    input  logic [CLASSES-1:0]            above,
    input  logic [CLASSES-1:0]            in_use,
    output logic [$clog2(CLASSES)-1:0]    win,
    output logic                          fallback
);
    import lhpc_pkg::*;

    localparam int IW = $clog2(CLASSES);

    logic [IW-1:0]                lo_idx, hi_idx;
    logic signed [SCORE_BITS-1:0] lo_val, hi_val, s;
    logic                         found;

    // Scan lanes for min above threshold and max overall.
    always_comb
    begin
        lo_idx = '0;
        hi_idx = '0;
        lo_val = '0;
        hi_val = $signed(scores[SCORE_BITS-1:0]);
        found  = 1'b0;
        for (int i = 0; i < CLASSES; i++)
        begin
            s = $signed(scores[i*SCORE_BITS +: SCORE_BITS]);
            if (in_use[i])
            begin
                if (above[i] && (!found || s < lo_val))
                begin
                    lo_val = s;
                    lo_idx = IW'(i);
                end
                if (above[i])
                    found = 1'b1;
                if (s > hi_val)
                begin
                    hi_val = s;
                    hi_idx = IW'(i);
                end
            end
        end
    end

    // Register the decision.
    always_ff @(posedge clk)
    begin
        win      <= found ? lo_idx : hi_idx;
        fallback <= !found;
    end

endmodule

// ----- design/linear_hyperplane_pixel_classifier.sv -----
// Top level: loader decode, class lanes, merge stage and result register.
// Linear hyperplane pixel classifier. Each class has a lane holding its band
// weights and bias; a pixel flows through products, per-lane sums with the
// bias compare, a merge picking the winner, then the color lookup and output
// register. One pixel is in flight at a time and the input stays closed until
// its result word is taken; a classify word while disabled also closes the
// input until its status word is taken, and loader words do not close it.
// Tables have no reset and must be written before classification.
module linear_hyperplane_pixel_classifier #(
    parameter int CLASSES     = lhpc_pkg::CLASSES_DEF,
    parameter int BANDS       = lhpc_pkg::BANDS_DEF,
    parameter int SAMPLE_BITS = lhpc_pkg::SAMPLE_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    lhpc_in_if.sink    pix,
    lhpc_out_if.source res,
    lhpc_cfg_if.sink   cfg
);
    import lhpc_pkg::*;

    localparam int IW   = $clog2(CLASSES);
    localparam int BW   = BANDS > 1 ? $clog2(BANDS) : 1;
    localparam int CCW  = $clog2(CLASSES + 1);
    localparam int SCW  = SAMPLE_BITS + WEIGHT_BITS + 1 + $clog2(BANDS + 1);

    logic [3:0]              class_count_reg;
    logic                    enabled_reg;
    logic [3:0]              busy_reg;
    logic                    res_valid_reg;
    logic [2:0]              chosen_reg;
    logic [COLOR_BITS-1:0]   color_out_reg;
    logic                    fallback_reg;
    logic                    status_reg;
    logic [COLOR_BITS-1:0]   color_reg [CLASSES];
    logic [CLASSES-1:0]      in_use_reg;
    logic [BANDS*SAMPLE_BITS-1:0] samples;
    logic [CLASSES*SCW-1:0]  scores;
    logic [CLASSES-1:0]      above;
    logic [IW-1:0]           win;
    logic                    fallback;
    logic                    accept, calc;
    logic [CCW-1:0]          used;

    assign accept    = pix.valid && pix.ready;
    assign pix.ready = busy_reg == '0 && !res_valid_reg;
    assign cfg.ready = 1'b1;
    assign calc      = accept && pix.mode == MODE_CLASSIFY && enabled_reg;

    // Clamp class count.
    always_comb
    begin
        if (class_count_reg == 4'd0)
            used = CCW'(1);
        else if (32'(class_count_reg) > CLASSES)
            used = CCW'(CLASSES);
        else
            used = CCW'(class_count_reg);
    end

    // Gather samples, masked; missing bands read zero.
    always_comb
    begin
        logic [11:0] f [SAMPLE_FIELDS];
        f[0] = pix.band_sample_0;
        f[1] = pix.band_sample_1;
        f[2] = pix.band_sample_2;
        f[3] = pix.band_sample_3;
        samples = '0;
        for (int b = 0; b < BANDS; b++)
            if (b < SAMPLE_FIELDS)
                samples[b*SAMPLE_BITS +: SAMPLE_BITS] =
                    SAMPLE_BITS'({{(SAMPLE_BITS > 12 ? SAMPLE_BITS - 12 : 0){1'b0}},
                                  f[b % SAMPLE_FIELDS]});
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_count_reg <= 4'd1;
            enabled_reg     <= 1'b0;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == CFG_CLASS_COUNT)
                class_count_reg <= cfg.data[3:0];
            else
                enabled_reg <= cfg.data[0];
        end
    end

    // Color table writes; latch lanes in use at pixel entry.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CLASSES; i++)
        begin
            if (accept && pix.mode == MODE_COLOR && 32'(pix.class_slot) == i)
                color_reg[i] <= pix.table_word[COLOR_BITS-1:0];
            if (calc)
                in_use_reg[i] <= i < 32'(used);
        end
    end

    // Class lanes.
    for (genvar g = 0; g < CLASSES; g++)
    begin : g_lane
        logic hit;
        assign hit = accept && 32'(pix.class_slot) == g;
        lhpc_lane #(.BANDS(BANDS), .SAMPLE_BITS(SAMPLE_BITS), .SCORE_BITS(SCW)) u_lane (
            .clk       (clk),
            .wr_weight (hit && pix.mode == MODE_WEIGHT && 32'(pix.band_slot) < BANDS),
            .wr_bias   (hit && pix.mode == MODE_BIAS),
            .wr_band   (BW'(pix.band_slot)),
            .wr_word   (pix.table_word),
            .calc      (calc),
            .samples   (samples),
            .score     (scores[g*SCW +: SCW]),
            .above     (above[g])
        );
    end

    lhpc_merge #(.CLASSES(CLASSES), .SCORE_BITS(SCW)) u_merge (
        .clk      (clk),
        .scores   (scores),
        .above    (above),
        .in_use   (in_use_reg),
        .win      (win),
        .fallback (fallback)
    );

    // Track the pixel in flight and hold the result word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= {busy_reg[2:0], calc};
            if (busy_reg[3] ||
                (accept && pix.mode == MODE_CLASSIFY && !enabled_reg))
                res_valid_reg <= 1'b1;
            else if (res.ready)
                res_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (busy_reg[3])
        begin
            chosen_reg    <= 3'(win);
            color_out_reg <= color_reg[win];
            fallback_reg  <= fallback;
            status_reg    <= STATUS_OK;
        end
        else if (accept && pix.mode == MODE_CLASSIFY && !enabled_reg)
        begin
            chosen_reg    <= '0;
            color_out_reg <= '0;
            fallback_reg  <= 1'b0;
            status_reg    <= STATUS_DISABLED;
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.chosen_class  = chosen_reg;
    assign res.color_red     = color_out_reg[23:16];
    assign res.color_green   = color_out_reg[15:8];
    assign res.color_blue    = color_out_reg[7:0];
    assign res.fallback_used = fallback_reg;
    assign res.status        = status_reg;

endmodule

// ----- test/lhpc_checker.sv -----
// Checker: watches the classifier channels, predicts each pixel result and compares.
`timescale 1ns / 100ps

module lhpc_checker (
    input  logic clk,
    input  logic rst_n,
    lhpc_in_if   pix,
    lhpc_out_if  res,
    lhpc_cfg_if  cfg,
    output int   errors,
    output int   pending
);
    import lhpc_pkg::*;

    typedef struct packed {
        logic [2:0] chosen;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       fallback;
        logic       status;
    } pixel_result_t;

    pixel_result_t result_q[$];

    // Shadow copies of the tables and registers
    logic [WEIGHT_BITS-1:0] weight_mem [CLASSES_DEF*BANDS_DEF];
    logic [BIAS_BITS-1:0]   bias_mem   [CLASSES_DEF];
    logic [COLOR_BITS-1:0]  color_mem  [CLASSES_DEF];
    logic [3:0]             class_cnt;
    logic                   enabled;

    function automatic pixel_result_t classify_pixel(logic [11:0] s0, logic [11:0] s1,
                                                     logic [11:0] s2, logic [11:0] s3);
        pixel_result_t r;
        longint score [CLASSES_DEF];
        logic [11:0] smp [BANDS_DEF];
        int used;
        int win;
        bit found;
        r = '0;
        smp[0] = s0; smp[1] = s1; smp[2] = s2; smp[3] = s3;
        if (!enabled) begin
            r.status = STATUS_DISABLED;
            return r;
        end
        used = (class_cnt == 0) ? 1 : (class_cnt > CLASSES_DEF) ? CLASSES_DEF : class_cnt;
        // score each class in use
        for (int c = 0; c < used; c++) begin
            score[c] = 0;
            for (int b = 0; b < BANDS_DEF; b++)
                score[c] += longint'({1'b0, smp[b]})
                            * longint'($signed(weight_mem[c*BANDS_DEF + b]));
        end
        // smallest score above its bias wins
        win = 0;
        found = 0;
        for (int c = 0; c < used; c++)
            if (score[c] > longint'($signed(bias_mem[c]))) begin
                if (!found || score[c] < score[win])
                    win = c;
                found = 1;
            end
        // otherwise fall back to the largest score
        if (!found) begin
            win = 0;
            for (int c = 1; c < used; c++)
                if (score[c] > score[win])
                    win = c;
        end
        r.chosen   = win[2:0];
        r.red      = color_mem[win][23:16];
        r.green    = color_mem[win][15:8];
        r.blue     = color_mem[win][7:0];
        r.fallback = !found;
        r.status   = STATUS_OK;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_result_t got;
        pixel_result_t want;
        if (!rst_n)
        begin
            class_cnt = 4'd1;
            enabled   = 1'b0;
            result_q.delete();
            errors   <= 0;
            pending  <= 0;
        end
        else
        begin
            // register writes
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_CLASS_COUNT)
                    class_cnt = cfg.data[3:0];
                else
                    enabled = cfg.data[0];
            end
            // accepted input word: load a table or predict a result
            if (pix.valid && pix.ready)
            begin
                case (mode_t'(pix.mode))
                    MODE_WEIGHT:
                        weight_mem[pix.class_slot*BANDS_DEF + pix.band_slot] =
                            pix.table_word[15:0];
                    MODE_BIAS:  bias_mem[pix.class_slot] = pix.table_word;
                    MODE_COLOR: color_mem[pix.class_slot] = pix.table_word[23:0];
                    default:
                        result_q.push_back(classify_pixel(pix.band_sample_0,
                            pix.band_sample_1, pix.band_sample_2, pix.band_sample_3));
                endcase
            end
            // accepted result word: compare with the oldest prediction
            if (res.valid && res.ready)
            begin
                got = {res.chosen_class, res.color_red, res.color_green, res.color_blue,
                       res.fallback_used, res.status};
                if (result_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("%0t: result with nothing predicted: class %0d status %0d",
                                 $realtime, got.chosen, got.status);
                    errors <= errors + 1;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (got.chosen != want.chosen || got.red != want.red
                        || got.green != want.green || got.blue != want.blue
                        || got.fallback != want.fallback || got.status != want.status)
                    begin
                        if (errors < 10)
                        begin
                            $write("%0t: mismatch exp class %0d rgb %h/%h/%h fb %0d st %0d,",
                                   $realtime, want.chosen, want.red, want.green, want.blue,
                                   want.fallback, want.status);
                            $display(" got class %0d rgb %h/%h/%h fb %0d st %0d",
                                     got.chosen, got.red, got.green, got.blue,
                                     got.fallback, got.status);
                        end
                        errors <= errors + 1;
                    end
                end
            end
            pending <= result_q.size();
        end
    end
endmodule

// ----- test/tb_linear_hyperplane_pixel_classifier.sv -----
// Testbench top: drives loader and pixel words, register writes, and gives the verdict.
`timescale 1ns / 100ps

module tb_linear_hyperplane_pixel_classifier;
    import lhpc_pkg::*;

    typedef struct {
        mode_t       mode;
        logic [2:0]  slot;
        logic [1:0]  band;
        logic [31:0] tword;
        logic [11:0] s [4];
    } feed_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   errors;
    int   pending;
    bit   quiet = 0;
    bit   hold_req = 0;
    int   pixels_sent = 0;
    int   loads_sent = 0;

    lhpc_in_if  pix ();
    lhpc_out_if res ();
    lhpc_cfg_if cfg ();

    linear_hyperplane_pixel_classifier uut (.clk(clk), .rst_n(rst_n), .pix(pix), .res(res),
                                            .cfg(cfg));
    lhpc_checker chk (.clk(clk), .rst_n(rst_n), .pix(pix), .res(res), .cfg(cfg),
                      .errors(errors), .pending(pending));

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Result side: random short stalls, one long hold-off on request
    initial
    begin
        int hold;
        hold = 0;
        res.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 0;
                hold = 120;
            end
            if (hold > 0)
            begin
                res.ready <= 1'b0;
                hold--;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                res.ready <= 1'b0;
                hold = $urandom_range(0, 2);
            end
            else
                res.ready <= 1'b1;
        end
    end

    // Offer one word and hold it until accepted, with an optional random gap first
    task automatic send_word(feed_t f);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            pix.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        pix.valid         <= 1'b1;
        pix.mode          <= f.mode;
        pix.class_slot    <= f.slot;
        pix.band_slot     <= f.band;
        pix.table_word    <= f.tword;
        pix.band_sample_0 <= f.s[0];
        pix.band_sample_1 <= f.s[1];
        pix.band_sample_2 <= f.s[2];
        pix.band_sample_3 <= f.s[3];
        @(posedge clk);
        while (!pix.ready) @(posedge clk);
        if (f.mode == MODE_CLASSIFY) pixels_sent++;
        else loads_sent++;
    endtask

    task automatic load(mode_t m, int c, int b, logic [31:0] w);
        feed_t f;
        f.mode = m; f.slot = 3'(c); f.band = 2'(b); f.tword = w;
        foreach (f.s[i]) f.s[i] = 12'($urandom);
        send_word(f);
    endtask

    task automatic classify(logic [11:0] a, logic [11:0] b, logic [11:0] c,
                            logic [11:0] d);
        feed_t f;
        f.mode = MODE_CLASSIFY; f.slot = 3'($urandom); f.band = 2'($urandom);
        f.tword = $urandom;
        f.s[0] = a; f.s[1] = b; f.s[2] = c; f.s[3] = d;
        send_word(f);
    endtask

    // Drain the block, then write one register
    task automatic write_reg(logic [0:0] idx, logic [31:0] val);
        pix.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        cfg.valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_bias();
        case ($urandom_range(0, 3))
            0: return $urandom;
            default: return $signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh1FFF_FFFF;
        endcase
    endfunction

    // Random word: mostly pixels, some table reloads
    task automatic random_word();
        int k;
        k = $urandom_range(0, 9);
        if (k < 7)
            classify(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
        else if (k == 7)
            load(MODE_WEIGHT, $urandom_range(0, 7), $urandom_range(0, 3), $urandom);
        else if (k == 8)
            load(MODE_BIAS, $urandom_range(0, 7), 0, rand_bias());
        else
            load(MODE_COLOR, $urandom_range(0, 7), 0, $urandom);
    endtask

    initial
    begin
        int counts [6] = '{8, 1, 0, 15, 3, 5};
        pix.valid = 1'b0;
        pix.mode = MODE_WEIGHT;
        pix.class_slot = '0;
        pix.band_slot = '0;
        pix.table_word = '0;
        pix.band_sample_0 = '0;
        pix.band_sample_1 = '0;
        pix.band_sample_2 = '0;
        pix.band_sample_3 = '0;
        cfg.valid = 1'b0;
        cfg.index = CFG_CLASS_COUNT;
        cfg.data = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Classify while disabled: status only, tables untouched
        classify(12'h000, 12'h000, 12'h000, 12'h000);
        classify(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);

        // Fill every table entry, weight extremes on class 0
        for (int c = 0; c < 8; c++)
        begin
            for (int b = 0; b < 4; b++)
                load(MODE_WEIGHT, c, b, (c == 0) ? ((b[0]) ? 32'h0000_8000 : 32'h0000_7FFF)
                                                 : $urandom);
            load(MODE_BIAS, c, 0, rand_bias());
            load(MODE_COLOR, c, 0, $urandom);
        end

        write_reg(CFG_CLASS_COUNT, 32'd8);
        write_reg(CFG_ENABLE, 32'd1);

        // Directed: sample extremes
        classify(12'h000, 12'h000, 12'h000, 12'h000);
        classify(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
        classify(12'hFFF, 12'h000, 12'hFFF, 12'h000);
        // Tie between classes 0 and 1, both above threshold
        for (int b = 0; b < 4; b++)
        begin
            load(MODE_WEIGHT, 0, b, 32'h0000_0100);
            load(MODE_WEIGHT, 1, b, 32'h0000_0100);
        end
        load(MODE_BIAS, 0, 0, 32'hFFFF_FFFB);
        load(MODE_BIAS, 1, 0, 32'hFFFF_FFFB);
        classify(12'h123, 12'h456, 12'h789, 12'hABC);
        // Same tie, classes 0 and 1 below threshold: fallback to lower index if no class is above
        load(MODE_BIAS, 0, 0, 32'h7FFF_FFFF);
        load(MODE_BIAS, 1, 0, 32'h7FFF_FFFF);
        classify(12'h000, 12'h000, 12'h000, 12'h000);

        // Random phases over several class counts
        foreach (counts[p])
        begin
            write_reg(CFG_CLASS_COUNT, counts[p]);
            if (p == 2) hold_req = 1;
            repeat (80) random_word();
        end

        // Disabled again, then back on with idling off for the last part
        write_reg(CFG_ENABLE, 32'd0);
        repeat (10) random_word();
        write_reg(CFG_ENABLE, 32'd1);
        write_reg(CFG_CLASS_COUNT, 32'd8);
        quiet = 1;
        repeat (50) random_word();
        pix.valid <= 1'b0;

        // Drain and settle
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Run covered %0d pixels and %0d table loads, disabled classification,",
                 pixels_sent, loads_sent);
        $display("class counts 0, 1, 3, 5, 8 and 15, ties, fallback and a long output stall.");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
